// ===== hw/rtl/sfcd_pkg.sv =====
// shared types, codes and widths for the spi flash command decoder
package sfcd_pkg;

  // field widths
  localparam int unsigned KindW  = 2;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned ClassW = 4;
  localparam int unsigned CmdW   = 4;
  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 3;
  localparam int unsigned PhaseW = 4;

  // reset value of the read address byte count
  localparam logic [CountW-1:0] ReadAddrBytesRst = 3'd2;

  // symbol kinds
  localparam logic [KindW-1:0] KIND_SELECT = 2'd0;
  localparam logic [KindW-1:0] KIND_DATA   = 2'd1;

  // transaction phases
  localparam logic [PhaseW-1:0] PH_IDLE       = 4'd0;
  localparam logic [PhaseW-1:0] PH_OPCODE     = 4'd1;
  localparam logic [PhaseW-1:0] PH_QUAD_ADDR  = 4'd2;
  localparam logic [PhaseW-1:0] PH_ADDR       = 4'd3;
  localparam logic [PhaseW-1:0] PH_READ       = 4'd4;
  localparam logic [PhaseW-1:0] PH_QUAD_READ  = 4'd5;
  localparam logic [PhaseW-1:0] PH_WRITE      = 4'd6;
  localparam logic [PhaseW-1:0] PH_DUMMY_ADDR = 4'd7;
  localparam logic [PhaseW-1:0] PH_DUMMY_DATA = 4'd8;

  // result symbol classes
  typedef enum logic [ClassW-1:0] {
    CL_CMD      = 4'd0,
    CL_DUMMY    = 4'd1,
    CL_ADDR     = 4'd2,
    CL_SR_ADDR  = 4'd3,
    CL_BLOCK    = 4'd4,
    CL_DATA     = 4'd5,
    CL_VENDOR   = 4'd6,
    CL_PART     = 4'd7,
    CL_PROT     = 4'd8,
    CL_CONFIG   = 4'd9,
    CL_STATUS   = 4'd10
  } sym_class_e;

  // decoded commands
  typedef enum logic [CmdW-1:0] {
    CMD_OTHER    = 4'd0,
    CMD_SOFT_RST = 4'd1,
    CMD_JEDEC    = 4'd2,
    CMD_RD_SR    = 4'd3,
    CMD_WR_SR    = 4'd4,
    CMD_R114     = 4'd5,
    CMD_R144     = 4'd6,
    CMD_RD_ARRAY = 4'd7,
    CMD_PAGE     = 4'd8
  } cmd_e;

  // opcodes on mosi
  localparam logic [ByteW-1:0] OP_RESET   = 8'hff;
  localparam logic [ByteW-1:0] OP_JEDEC   = 8'h9f;
  localparam logic [ByteW-1:0] OP_RD_SR_A = 8'h0f;
  localparam logic [ByteW-1:0] OP_RD_SR_B = 8'h5f;
  localparam logic [ByteW-1:0] OP_WR_SR_A = 8'h01;
  localparam logic [ByteW-1:0] OP_WR_SR_B = 8'h1f;
  localparam logic [ByteW-1:0] OP_R114    = 8'h6b;
  localparam logic [ByteW-1:0] OP_R144    = 8'heb;
  localparam logic [ByteW-1:0] OP_READ    = 8'h03;
  localparam logic [ByteW-1:0] OP_PAGE    = 8'h13;

  // status register address groups (high nibble)
  localparam logic [3:0] SR_GRP_PROT   = 4'ha;
  localparam logic [3:0] SR_GRP_CONFIG = 4'hb;
  localparam logic [3:0] SR_GRP_STATUS = 4'hc;

endpackage

// ===== hw/rtl/sfcd_in_if.sv =====
// input symbol channel of the spi flash command decoder
interface sfcd_in_if;
  import sfcd_pkg::*;

  logic             valid;
  logic             ready;
  logic [KindW-1:0] symbol_kind;
  logic [ByteW-1:0] mosi_byte;
  logic [ByteW-1:0] miso_byte;

  modport source (output valid, output symbol_kind, output mosi_byte, output miso_byte,
                  input ready);
  modport sink (input valid, input symbol_kind, input mosi_byte, input miso_byte,
                output ready);
endinterface

// ===== hw/rtl/sfcd_out_if.sv =====
// annotated symbol channel of the spi flash command decoder
interface sfcd_out_if;
  import sfcd_pkg::*;

  logic              valid;
  logic              ready;
  logic [ClassW-1:0] symbol_class;
  logic [CmdW-1:0]   command_code;
  logic [ValueW-1:0] symbol_value;
  logic              replaces_previous;

  modport source (output valid, output symbol_class, output command_code,
                  output symbol_value, output replaces_previous, input ready);
  modport sink (input valid, input symbol_class, input command_code,
                input symbol_value, input replaces_previous, output ready);
endinterface

// ===== hw/rtl/sfcd_cfg_if.sv =====
// configuration write channel of the spi flash command decoder
interface sfcd_cfg_if;
  import sfcd_pkg::*;

  logic              valid;
  logic              ready;
  logic [CountW-1:0] read_address_bytes;

  modport source (output valid, output read_address_bytes, input ready);
  modport sink (input valid, input read_address_bytes, output ready);
endinterface

// ===== hw/rtl/spi_flash_command_decoder.sv =====
// spi flash command decoder: annotates flash transactions in a decoded spi symbol stream
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    symbol_kind, mosi_byte, miso_byte
//   out_o    out  valid/ready    symbol_class, command_code, symbol_value, replaces_previous
//   cfg_i    in   valid/ready    read_address_bytes (always ready)
//
// an item is registered on entry and then decoded straight into the result
// register, and one item is accepted per cycle unless the decode waits. the decode
// waits only while a result sits untaken in the result register. reset puts the
// phase machine and all transaction state back to their reset values.
module spi_flash_command_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  sfcd_in_if.sink     in_i,
  sfcd_out_if.source  out_o,
  sfcd_cfg_if.sink    cfg_i
);
  import sfcd_pkg::*;

  // input register
  logic             in_vld_q;
  logic [KindW-1:0] kind_q;
  logic [ByteW-1:0] mosi_q;
  logic [ByteW-1:0] miso_q;

  // transaction state
  logic [PhaseW-1:0] phase_q, phase_d;
  cmd_e              cmd_q, cmd_d;
  logic [CountW-1:0] remain_q, remain_d;
  logic [ValueW-1:0] acc_q, acc_d;
  sym_class_e        exp_cls_q, exp_cls_d;
  sym_class_e        last_cls_q, last_cls_d;
  logic [ValueW-1:0] last_val_q, last_val_d;
  logic [CountW-1:0] rd_addr_bytes_q;

  // result register
  logic              out_vld_q, out_vld_d;
  sym_class_e        res_cls_q, res_cls_d;
  cmd_e              res_cmd_q, res_cmd_d;
  logic [ValueW-1:0] res_val_q, res_val_d;
  logic              res_rep_q, res_rep_d;

  logic              proc;
  logic              emit;
  logic              is_data;
  logic [ValueW-1:0] acc_shift;
  logic [CountW-1:0] remain_dec;

  // handshakes
  assign proc        = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready  = !in_vld_q || proc;
  assign cfg_i.ready = 1'b1;

  assign is_data    = (kind_q == KIND_DATA);
  assign acc_shift  = {acc_q[ValueW-ByteW-1:0], mosi_q};
  assign remain_dec = remain_q - 3'd1;

  // decode one symbol
  always_comb begin
    phase_d   = phase_q;
    cmd_d     = cmd_q;
    remain_d  = remain_q;
    acc_d     = acc_q;
    exp_cls_d = exp_cls_q;
    emit      = 1'b0;
    res_cls_d = CL_CMD;
    res_cmd_d = CMD_OTHER;
    res_val_d = '0;
    res_rep_d = 1'b0;

    unique case (phase_q) inside
      PH_OPCODE: begin
        if (!is_data) begin
          phase_d = PH_IDLE;
        end else begin
          unique case (mosi_q) inside
            OP_RESET: begin
              cmd_d   = CMD_SOFT_RST;
              phase_d = PH_IDLE;
            end
            OP_JEDEC: begin
              cmd_d     = CMD_JEDEC;
              phase_d   = PH_DUMMY_DATA;
              exp_cls_d = CL_VENDOR;
            end
            OP_RD_SR_A, OP_RD_SR_B: begin
              cmd_d    = CMD_RD_SR;
              phase_d  = PH_ADDR;
              remain_d = 3'd1;
              acc_d    = '0;
            end
            OP_WR_SR_A, OP_WR_SR_B: begin
              cmd_d    = CMD_WR_SR;
              phase_d  = PH_ADDR;
              remain_d = 3'd1;
              acc_d    = '0;
            end
            OP_R114: begin
              cmd_d    = CMD_R114;
              phase_d  = PH_ADDR;
              remain_d = rd_addr_bytes_q;
              acc_d    = '0;
            end
            OP_R144: begin
              cmd_d    = CMD_R144;
              phase_d  = PH_QUAD_ADDR;
              remain_d = rd_addr_bytes_q;
              acc_d    = '0;
            end
            OP_READ: begin
              cmd_d    = CMD_RD_ARRAY;
              phase_d  = PH_ADDR;
              remain_d = rd_addr_bytes_q;
              acc_d    = '0;
            end
            OP_PAGE: begin
              cmd_d    = CMD_PAGE;
              phase_d  = PH_DUMMY_ADDR;
              remain_d = rd_addr_bytes_q;
              acc_d    = '0;
            end
            default: begin
              cmd_d   = CMD_OTHER;
              phase_d = PH_IDLE;
            end
          endcase
          emit      = 1'b1;
          res_cls_d = CL_CMD;
          res_cmd_d = cmd_d;
        end
      end

      PH_DUMMY_ADDR: begin
        phase_d   = is_data ? PH_ADDR : PH_IDLE;
        emit      = 1'b1;
        res_cls_d = CL_DUMMY;
      end

      PH_DUMMY_DATA: begin
        if (!is_data) begin
          phase_d = PH_IDLE;
        end else if (cmd_q == CMD_R114 || cmd_q == CMD_R144) begin
          phase_d = PH_QUAD_READ;
        end else begin
          phase_d = PH_READ;
        end
        emit      = 1'b1;
        res_cls_d = CL_DUMMY;
      end

      PH_QUAD_ADDR, PH_QUAD_READ: begin
        if (!is_data) begin
          phase_d = PH_IDLE;
        end
      end

      PH_ADDR: begin
        if (!is_data) begin
          phase_d = PH_IDLE;
        end else begin
          acc_d    = acc_shift;
          remain_d = remain_dec;
          // last address byte closes the address phase
          if (remain_dec == '0) begin
            exp_cls_d = CL_DATA;
            res_cls_d = CL_ADDR;
            phase_d   = PH_READ;
            case (cmd_q) inside
              CMD_RD_ARRAY, CMD_R114: begin
                phase_d = PH_DUMMY_DATA;
              end
              CMD_RD_SR, CMD_WR_SR: begin
                case (acc_shift[7:4])
                  SR_GRP_PROT:   exp_cls_d = CL_PROT;
                  SR_GRP_CONFIG: exp_cls_d = CL_CONFIG;
                  SR_GRP_STATUS: exp_cls_d = CL_STATUS;
                  default:       exp_cls_d = CL_DATA;
                endcase
                if (cmd_q == CMD_WR_SR) begin
                  phase_d = PH_WRITE;
                end
                res_cls_d = CL_SR_ADDR;
              end
              CMD_PAGE: begin
                res_cls_d = CL_BLOCK;
              end
              default: begin
                res_cls_d = CL_ADDR;
              end
            endcase
            emit      = 1'b1;
            res_val_d = acc_shift;
          end
        end
      end

      PH_READ: begin
        if (!is_data) begin
          phase_d = PH_IDLE;
        end else if (exp_cls_q == CL_PART && last_cls_q == CL_PART) begin
          // part id grows in place
          emit      = 1'b1;
          res_cls_d = CL_PART;
          res_val_d = {last_val_q[ValueW-ByteW-1:0], miso_q};
          res_rep_d = 1'b1;
        end else begin
          emit      = 1'b1;
          res_cls_d = exp_cls_q;
          res_val_d = {{(ValueW-ByteW){1'b0}}, miso_q};
          if (exp_cls_q == CL_VENDOR) begin
            exp_cls_d = CL_PART;
          end
        end
      end

      PH_WRITE: begin
        if (!is_data) begin
          phase_d = PH_IDLE;
        end else begin
          emit      = 1'b1;
          res_cls_d = exp_cls_q;
          res_val_d = {{(ValueW-ByteW){1'b0}}, mosi_q};
        end
      end

      default: begin
        phase_d = (kind_q == KIND_SELECT) ? PH_OPCODE : PH_IDLE;
      end
    endcase
  end

  // last emitted symbol tracking
  always_comb begin
    last_cls_d = last_cls_q;
    last_val_d = last_val_q;
    if (emit) begin
      last_cls_d = res_cls_d;
      last_val_d = res_val_d;
    end
  end

  // result register valid
  always_comb begin
    if (proc) begin
      out_vld_d = emit;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q        <= 1'b0;
      out_vld_q       <= 1'b0;
      phase_q         <= PH_IDLE;
      cmd_q           <= CMD_OTHER;
      remain_q        <= '0;
      acc_q           <= '0;
      exp_cls_q       <= CL_DATA;
      last_cls_q      <= CL_CMD;
      last_val_q      <= '0;
      rd_addr_bytes_q <= ReadAddrBytesRst;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      out_vld_q <= out_vld_d;
      if (proc) begin
        phase_q    <= phase_d;
        cmd_q      <= cmd_d;
        remain_q   <= remain_d;
        acc_q      <= acc_d;
        exp_cls_q  <= exp_cls_d;
        last_cls_q <= last_cls_d;
        last_val_q <= last_val_d;
      end
      if (cfg_i.valid) begin
        rd_addr_bytes_q <= cfg_i.read_address_bytes;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      kind_q <= in_i.symbol_kind;
      mosi_q <= in_i.mosi_byte;
      miso_q <= in_i.miso_byte;
    end
    if (proc && emit) begin
      res_cls_q <= res_cls_d;
      res_cmd_q <= res_cmd_d;
      res_val_q <= res_val_d;
      res_rep_q <= res_rep_d;
    end
  end

  // result outputs
  assign out_o.valid             = out_vld_q;
  assign out_o.symbol_class      = res_cls_q;
  assign out_o.command_code      = res_cmd_q;
  assign out_o.symbol_value      = res_val_q;
  assign out_o.replaces_previous = res_rep_q;

endmodule

// ===== tb/sv/sfcd_annot_board_pkg.sv =====
// scoreboard class: predicts and checks annotated spi flash symbols
package sfcd_annot_board_pkg;
  import sfcd_pkg::*;

  // one expected annotated symbol
  typedef struct {
    sym_class_e        cls;
    cmd_e              cmd;
    logic [ValueW-1:0] value;
    logic              rep;
  } annot_t;

  class sfcd_annot_board;
    // register copy and decoder state
    logic [CountW-1:0] read_addr_bytes;
    logic [PhaseW-1:0] phase;
    cmd_e              cur_cmd;
    logic [CountW-1:0] addr_left;
    logic [ValueW-1:0] addr_acc;
    sym_class_e        data_cls;
    sym_class_e        last_cls;
    logic [ValueW-1:0] last_val;

    annot_t      expected_q[$];
    int unsigned checked;
    int unsigned failures;
    int unsigned part_updates;

    function new();
      read_addr_bytes = ReadAddrBytesRst;
      phase           = PH_IDLE;
      cur_cmd         = CMD_OTHER;
      addr_left       = '0;
      addr_acc        = '0;
      data_cls        = CL_DATA;
      last_cls        = CL_CMD;
      last_val        = '0;
      checked         = 0;
      failures        = 0;
      part_updates    = 0;
    endfunction

    function void set_read_address_bytes(logic [CountW-1:0] count);
      read_addr_bytes = count;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void start_addr(logic [CountW-1:0] count);
      addr_left = count;
      addr_acc  = '0;
    endfunction

    // advance the decoder by one accepted item, queue the annotation it causes
    function void note_symbol(logic [KindW-1:0] kind, logic [ByteW-1:0] mosi,
                              logic [ByteW-1:0] miso);
      logic       is_data;
      logic       hit;
      annot_t     r;
      sym_class_e acls;
      is_data = (kind == KIND_DATA);
      hit     = 1'b0;
      r.cls   = CL_CMD;
      r.cmd   = CMD_OTHER;
      r.value = '0;
      r.rep   = 1'b0;
      case (phase)
        PH_OPCODE: begin
          if (!is_data) begin
            phase = PH_IDLE;
          end else begin
            case (mosi)
              OP_RESET: begin
                cur_cmd = CMD_SOFT_RST;
                phase   = PH_IDLE;
              end
              OP_JEDEC: begin
                cur_cmd  = CMD_JEDEC;
                phase    = PH_DUMMY_DATA;
                data_cls = CL_VENDOR;
              end
              OP_RD_SR_A, OP_RD_SR_B: begin
                cur_cmd = CMD_RD_SR;
                phase   = PH_ADDR;
                start_addr(CountW'(1));
              end
              OP_WR_SR_A, OP_WR_SR_B: begin
                cur_cmd = CMD_WR_SR;
                phase   = PH_ADDR;
                start_addr(CountW'(1));
              end
              OP_R114: begin
                cur_cmd = CMD_R114;
                phase   = PH_ADDR;
                start_addr(read_addr_bytes);
              end
              OP_R144: begin
                cur_cmd = CMD_R144;
                phase   = PH_QUAD_ADDR;
                start_addr(read_addr_bytes);
              end
              OP_READ: begin
                cur_cmd = CMD_RD_ARRAY;
                phase   = PH_ADDR;
                start_addr(read_addr_bytes);
              end
              OP_PAGE: begin
                cur_cmd = CMD_PAGE;
                phase   = PH_DUMMY_ADDR;
                start_addr(read_addr_bytes);
              end
              default: begin
                cur_cmd = CMD_OTHER;
                phase   = PH_IDLE;
              end
            endcase
            hit   = 1'b1;
            r.cls = CL_CMD;
            r.cmd = cur_cmd;
          end
        end
        PH_DUMMY_ADDR: begin
          phase = is_data ? PH_ADDR : PH_IDLE;
          hit   = 1'b1;
          r.cls = CL_DUMMY;
        end
        PH_DUMMY_DATA: begin
          if (!is_data) phase = PH_IDLE;
          else if (cur_cmd == CMD_R114 || cur_cmd == CMD_R144) phase = PH_QUAD_READ;
          else phase = PH_READ;
          hit   = 1'b1;
          r.cls = CL_DUMMY;
        end
        PH_QUAD_ADDR, PH_QUAD_READ: begin
          if (!is_data) phase = PH_IDLE;
        end
        PH_ADDR: begin
          if (!is_data) begin
            phase = PH_IDLE;
          end else begin
            addr_acc  = {addr_acc[ValueW-ByteW-1:0], mosi};
            addr_left = addr_left - 1'b1;
            if (addr_left == '0) begin
              data_cls = CL_DATA;
              acls     = CL_ADDR;
              phase    = PH_READ;
              case (cur_cmd)
                CMD_RD_ARRAY, CMD_R114: phase = PH_DUMMY_DATA;
                CMD_RD_SR, CMD_WR_SR: begin
                  // the register address nibble picks the data label
                  case (addr_acc[7:4])
                    SR_GRP_PROT:   data_cls = CL_PROT;
                    SR_GRP_CONFIG: data_cls = CL_CONFIG;
                    SR_GRP_STATUS: data_cls = CL_STATUS;
                    default:       data_cls = data_cls;
                  endcase
                  if (cur_cmd == CMD_WR_SR) phase = PH_WRITE;
                  acls = CL_SR_ADDR;
                end
                CMD_PAGE: acls = CL_BLOCK;
                default:  acls = CL_ADDR;
              endcase
              hit     = 1'b1;
              r.cls   = acls;
              r.value = addr_acc;
            end
          end
        end
        PH_READ: begin
          if (!is_data) begin
            phase = PH_IDLE;
          end else if (data_cls == CL_PART && last_cls == CL_PART) begin
            // part id grows in place
            hit     = 1'b1;
            r.cls   = CL_PART;
            r.value = {last_val[ValueW-ByteW-1:0], miso};
            r.rep   = 1'b1;
          end else begin
            hit     = 1'b1;
            r.cls   = data_cls;
            r.value = ValueW'(miso);
            if (data_cls == CL_VENDOR) data_cls = CL_PART;
          end
        end
        PH_WRITE: begin
          if (!is_data) begin
            phase = PH_IDLE;
          end else begin
            hit     = 1'b1;
            r.cls   = data_cls;
            r.value = ValueW'(mosi);
          end
        end
        default: begin
          phase = (kind == KIND_SELECT) ? PH_OPCODE : PH_IDLE;
        end
      endcase
      if (hit) begin
        last_cls = r.cls;
        last_val = r.value;
        expected_q.insert(expected_q.size(), r);
      end
    endfunction

    // compare one accepted annotation against the oldest prediction
    function void check_symbol(logic [ClassW-1:0] cls, logic [CmdW-1:0] cmd,
                               logic [ValueW-1:0] value, logic rep);
      annot_t want;
      if (expected_q.size() == 0) begin
        failures++;
        $error("unexpected annotation: symbol_class %0d symbol_value %h", cls, value);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (rep === 1'b1) part_updates++;
      if (cls !== want.cls) begin
        failures++;
        $error("symbol_class: expected %0d, actual %0d", want.cls, cls);
      end
      if (cmd !== want.cmd) begin
        failures++;
        $error("command_code: expected %0d, actual %0d", want.cmd, cmd);
      end
      if (value !== want.value) begin
        failures++;
        $error("symbol_value: expected %h, actual %h", want.value, value);
      end
      if (rep !== want.rep) begin
        failures++;
        $error("replaces_previous: expected %b, actual %b", want.rep, rep);
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/tb.sv =====
// testbench top for the spi flash command decoder
module tb;
  import sfcd_pkg::*;
  import sfcd_annot_board_pkg::*;

  localparam logic [KindW-1:0] KIND_DESELECT = 2'd2;
  localparam logic [KindW-1:0] KIND_OTHER    = 2'd3;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned DIRECTED_ITEMS = 25;
  localparam int unsigned ITEMS_PER_SET  = 158;
  localparam int unsigned NUM_SETS       = 9;

  logic clk_i;
  logic rst_ni;

  sfcd_in_if  in_if ();
  sfcd_out_if out_if ();
  sfcd_cfg_if cfg_if ();

  spi_flash_command_decoder uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  sfcd_annot_board sb = new();

  int unsigned sent_items;
  int unsigned cycle_count;
  bit          calm_tail;
  bit          long_hold_done;

  // address byte counts per setting, extremes and out-of-range values included
  logic [CountW-1:0] addr_settings [NUM_SETS] = '{3'd2, 3'd4, 3'd1, 3'd0, 3'd7,
                                                  3'd5, 3'd3, 3'd6, 3'd2};

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // offer one item, with an occasional gap before it, and wait for acceptance
  task automatic send_symbol(input logic [KindW-1:0] kind, input logic [ByteW-1:0] mosi,
                             input logic [ByteW-1:0] miso);
    if (!calm_tail && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.symbol_kind <= kind;
    in_if.mosi_byte   <= mosi;
    in_if.miso_byte   <= miso;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_symbol(kind, mosi, miso);
    sent_items++;
  endtask

  // one flash transaction with random content, or a short run of noise
  task automatic send_transaction();
    logic [ByteW-1:0] op;
    logic [KindW-1:0] tail_kind;
    int unsigned      n;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 4))
        send_symbol(KindW'($urandom_range(0, 3)), ByteW'($urandom), ByteW'($urandom));
      return;
    end
    case ($urandom_range(0, 11))
      0:       op = OP_RESET;
      1:       op = OP_JEDEC;
      2:       op = OP_RD_SR_A;
      3:       op = OP_RD_SR_B;
      4:       op = OP_WR_SR_A;
      5:       op = OP_WR_SR_B;
      6:       op = OP_R114;
      7:       op = OP_R144;
      8:       op = OP_READ;
      9:       op = OP_PAGE;
      default: op = ByteW'($urandom);
    endcase
    send_symbol(KIND_SELECT, ByteW'($urandom), ByteW'($urandom));
    send_symbol(KIND_DATA, op, ByteW'($urandom));
    n = $urandom_range(0, 14);
    repeat (n) send_symbol(KIND_DATA, ByteW'($urandom), ByteW'($urandom));
    case ($urandom_range(0, 2))
      0:       tail_kind = KIND_SELECT;
      1:       tail_kind = KIND_DESELECT;
      default: tail_kind = KIND_OTHER;
    endcase
    send_symbol(tail_kind, ByteW'($urandom), ByteW'($urandom));
  endtask

  // stop offering and let every expected result and any in-flight item drain
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_read_address_bytes(input logic [CountW-1:0] count);
    cfg_if.valid              <= 1'b1;
    cfg_if.read_address_bytes <= count;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    sb.set_read_address_bytes(count);
    cfg_if.valid <= 1'b0;
  endtask

  // result sink with random stalls and one long hold-off
  initial begin
    int unsigned stall_left;
    stall_left     = 0;
    long_hold_done = 1'b0;
    out_if.ready <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (!long_hold_done && sb.checked >= 150) begin
        long_hold_done = 1'b1;
        stall_left     = LONG_HOLD - 1;
        out_if.ready <= 1'b0;
      end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_symbol(out_if.symbol_class, out_if.command_code, out_if.symbol_value,
                      out_if.replaces_previous);
  end

  // main sequence
  initial begin
    int unsigned target;
    sent_items  = 0;
    calm_tail   = 1'b0;
    rst_ni                    <= 1'b0;
    in_if.valid               <= 1'b0;
    in_if.symbol_kind         <= KIND_SELECT;
    in_if.mosi_byte           <= '0;
    in_if.miso_byte           <= '0;
    cfg_if.valid              <= 1'b0;
    cfg_if.read_address_bytes <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle noise, reset, unknown opcode, jedec id with part id growth
    send_symbol(KIND_OTHER, 8'hff, 8'h00);
    send_symbol(KIND_SELECT, 8'h00, 8'hff);
    send_symbol(KIND_DATA, OP_RESET, 8'h00);
    send_symbol(KIND_SELECT, 8'hff, 8'hff);
    send_symbol(KIND_DATA, 8'h00, 8'hff);
    send_symbol(KIND_SELECT, 8'h00, 8'h00);
    send_symbol(KIND_DATA, OP_JEDEC, 8'h00);
    send_symbol(KIND_DATA, 8'h00, 8'h00);
    send_symbol(KIND_DATA, 8'h00, 8'hff);
    send_symbol(KIND_DATA, 8'h00, 8'h00);
    send_symbol(KIND_DATA, 8'h00, 8'h5a);
    send_symbol(KIND_OTHER, 8'h00, 8'h00);
    // status read, status group
    send_symbol(KIND_SELECT, 8'h00, 8'h00);
    send_symbol(KIND_DATA, OP_RD_SR_A, 8'h00);
    send_symbol(KIND_DATA, 8'hc3, 8'h00);
    send_symbol(KIND_DATA, 8'h00, 8'ha5);
    send_symbol(KIND_DESELECT, 8'h00, 8'h00);
    // status write to protection, ended by a chip select mid-transaction
    send_symbol(KIND_SELECT, 8'h00, 8'h00);
    send_symbol(KIND_DATA, OP_WR_SR_B, 8'h00);
    send_symbol(KIND_DATA, 8'ha0, 8'h00);
    send_symbol(KIND_DATA, 8'hff, 8'h00);
    send_symbol(KIND_SELECT, 8'h00, 8'h00);
    // page read cut off in its dummy byte
    send_symbol(KIND_SELECT, 8'h00, 8'h00);
    send_symbol(KIND_DATA, OP_PAGE, 8'h00);
    send_symbol(KIND_DESELECT, 8'h00, 8'h00);

    // random transactions under each address byte setting
    target = DIRECTED_ITEMS;
    for (int s = 0; s < NUM_SETS; s++) begin
      drain();
      if (s == NUM_SETS - 1) calm_tail = 1'b1;
      if (s != 0) write_read_address_bytes(addr_settings[s]);
      target += ITEMS_PER_SET;
      while (sent_items < target) send_transaction();
    end

    drain();
    $display("%0d items sent across %0d address byte settings", sent_items, NUM_SETS);
    $display("%0d annotations checked, %0d of them part id updates",
             sb.checked, sb.part_updates);
    if (sb.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
